// File: hdl/pfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfp_pkg: shared types and constants of the particle frame parser
// Frame layout constants, field widths and the result/status structs.
// ----------------------------------------------------------------------------
package pfp_pkg;

  localparam int unsigned FRAME_LENGTH_DEF = 32;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 14;
  localparam int unsigned HIGH_W  = COUNT_W - BYTE_W;
  // Holds the sum of up to 30 bytes without wrapping.
  localparam int unsigned SUM_W   = 13;
  localparam int unsigned CSUM_W  = 2 * BYTE_W;
  localparam int unsigned N_COUNTS = 3;

  localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'h42;
  localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h4D;

  // Frame byte index of the high byte of the first count; the counts follow
  // back to back, two bytes each.
  localparam int unsigned COUNT_BASE_POS = 4;
  // Index of the first byte after the header.
  localparam int unsigned BODY_START_POS = 2;

  typedef struct packed {
    logic [COUNT_W-1:0] pm1_count;
    logic [COUNT_W-1:0] pm25_count;
    logic [COUNT_W-1:0] pm10_count;
    logic               checksum_ok;
  } result_t;

  typedef struct packed {
    logic in_frame;
    logic header_half_seen;
  } status_t;

endpackage

`default_nettype wire

// File: hdl/pfp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfp_byte_if / pfp_result_if: valid/ready channels of the frame parser
// A beat moves when valid and ready are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface pfp_byte_if;
  logic                         valid;
  logic                         ready;
  logic [pfp_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pfp_result_if;
  logic                          valid;
  logic                          ready;
  logic [pfp_pkg::COUNT_W-1:0]   pm1_count;
  logic [pfp_pkg::COUNT_W-1:0]   pm25_count;
  logic [pfp_pkg::COUNT_W-1:0]   pm10_count;
  logic                          checksum_ok;

  modport source (output valid, output pm1_count, output pm25_count,
                  output pm10_count, output checksum_ok, input ready);
  modport sink   (input valid, input pm1_count, input pm25_count,
                  input pm10_count, input checksum_ok, output ready);
endinterface

`default_nettype wire

// File: hdl/particle_frame_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// particle_frame_parser: 32-byte particle sensor frame parser
// Hunts for the 0x42 0x4D header, sums the frame, captures three counts and
// checks the trailing big-endian checksum.
// ----------------------------------------------------------------------------
// Usage:
//   byte_i   sink channel, one received serial byte per beat.
//   result_o source channel, one beat per complete frame: three 14-bit
//            counts from frame bytes 4..9 and a checksum match flag.
//   Bytes pass through an input register, then the frame logic updates the
//   state on each advance; the last byte of a frame loads the result register.
//   A frame's last byte goes through the input register, then the result
//   register. Throughput: one byte per cycle but for receiver stalls, set
//   by the single frame-logic stage.
//   Reset clears the hunt state, the frame position and both valid flags;
//   the block comes out of reset hunting for a header.
//   Receiver stall: the waiting result holds; bytes that end no frame keep
//   flowing. Only the last byte of the next frame waits in the input
//   register, and byte_i.ready drops once that register is full.
//   Header bytes inside a frame are data; resync happens only at frame end.
// ----------------------------------------------------------------------------
module particle_frame_parser #(
  parameter int unsigned FRAME_LENGTH = pfp_pkg::FRAME_LENGTH_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  pfp_byte_if.sink       byte_i,
  pfp_result_if.source   result_o
);

  logic                        in_valid_q;
  logic [pfp_pkg::BYTE_W-1:0]  in_byte_q;
  logic                        advance;
  logic                        emit;
  logic                        out_can_take;
  logic                        out_valid;
  pfp_pkg::result_t            frame_result;
  pfp_pkg::result_t            out_result;
  pfp_pkg::status_t            status;

  // Advance the held byte unless it ends a frame and the result register
  // is still full.
  assign advance      = in_valid_q && (!emit || out_can_take);
  assign byte_i.ready = !in_valid_q || advance;

  // Input register: hold one byte ahead of the frame logic.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (byte_i.ready) begin
      in_valid_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.ready && byte_i.valid) begin
      in_byte_q <= byte_i.rx_byte;
    end
  end

  pfp_frame #(
    .FRAME_LENGTH (FRAME_LENGTH)
  ) u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .byte_i    (in_byte_q),
    .emit_o    (emit),
    .result_o  (frame_result),
    .status_o  (status)
  );

  pfp_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance && emit),
    .result_i   (frame_result),
    .ready_i    (result_o.ready),
    .valid_o    (out_valid),
    .can_take_o (out_can_take),
    .result_o   (out_result)
  );

  assign result_o.valid       = out_valid;
  assign result_o.pm1_count   = out_result.pm1_count;
  assign result_o.pm25_count  = out_result.pm25_count;
  assign result_o.pm10_count  = out_result.pm10_count;
  assign result_o.checksum_ok = out_result.checksum_ok;

  // A frame result must leave the parser back in the hunt state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && emit) |=> (!status.in_frame && !status.header_half_seen))
    else $error("parser did not return to hunting after a frame");

  // A stalled byte in the input register must not be lost or changed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_byte_q)))
    else $error("held input byte dropped or changed");

  // A result is emitted only while a frame is being collected.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> status.in_frame)
    else $error("result flagged outside a frame");

  // An untaken result stays valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !result_o.ready) |=> out_valid)
    else $error("pending result dropped");

endmodule

`default_nettype wire

// File: hdl/pfp_frame.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfp_frame: header hunt, frame position, running sum and count capture
// Updates the frame state by one byte on each advance and flags the last byte.
// ----------------------------------------------------------------------------
module pfp_frame #(
  parameter int unsigned FRAME_LENGTH = pfp_pkg::FRAME_LENGTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        advance_i,
  input  wire logic [pfp_pkg::BYTE_W-1:0]  byte_i,
  output      logic                        emit_o,
  output      pfp_pkg::result_t            result_o,
  output      pfp_pkg::status_t            status_o
);

  localparam int unsigned POS_W = $clog2(FRAME_LENGTH);
  localparam logic [POS_W-1:0] CSUM_HI_POS = POS_W'(FRAME_LENGTH - 2);
  localparam logic [POS_W-1:0] LAST_POS    = POS_W'(FRAME_LENGTH - 1);
  localparam logic [POS_W-1:0] START_POS   = POS_W'(pfp_pkg::BODY_START_POS);
  localparam logic [pfp_pkg::SUM_W-1:0] HDR_SUM =
    pfp_pkg::SUM_W'(pfp_pkg::HDR_FIRST) + pfp_pkg::SUM_W'(pfp_pkg::HDR_SECOND);

  logic                             in_frame_q, in_frame_d;
  logic                             half_seen_q, half_seen_d;
  logic [POS_W-1:0]                 pos_q, pos_d;
  logic [pfp_pkg::SUM_W-1:0]        sum_q, sum_d;
  logic [pfp_pkg::BYTE_W-1:0]       csum_hi_q, csum_hi_d;
  logic [pfp_pkg::COUNT_W-1:0]      cnt_q [pfp_pkg::N_COUNTS];
  logic [pfp_pkg::COUNT_W-1:0]      cnt_d [pfp_pkg::N_COUNTS];
  logic [pfp_pkg::CSUM_W-1:0]       csum_rx;

  assign csum_rx = {csum_hi_q, byte_i};
  assign emit_o  = in_frame_q && (pos_q == LAST_POS);

  always_comb begin
    result_o.pm1_count   = cnt_q[0];
    result_o.pm25_count  = cnt_q[1];
    result_o.pm10_count  = cnt_q[2];
    result_o.checksum_ok = (csum_rx == pfp_pkg::CSUM_W'(sum_q));
  end

  assign status_o.in_frame         = in_frame_q;
  assign status_o.header_half_seen = half_seen_q;

  always_comb begin
    in_frame_d  = in_frame_q;
    half_seen_d = half_seen_q;
    pos_d       = pos_q;
    sum_d       = sum_q;
    csum_hi_d   = csum_hi_q;
    cnt_d       = cnt_q;
    if (!in_frame_q) begin
      if (half_seen_q && (byte_i == pfp_pkg::HDR_SECOND)) begin
        in_frame_d  = 1'b1;
        half_seen_d = 1'b0;
        pos_d       = START_POS;
        sum_d       = HDR_SUM;
      end else begin
        half_seen_d = (byte_i == pfp_pkg::HDR_FIRST);
      end
    end else if (pos_q == LAST_POS) begin
      // Close the frame and go back to hunting.
      in_frame_d  = 1'b0;
      half_seen_d = 1'b0;
      pos_d       = '0;
    end else if (pos_q == CSUM_HI_POS) begin
      csum_hi_d = byte_i;
      pos_d     = pos_q + 1'b1;
    end else begin
      sum_d = sum_q + pfp_pkg::SUM_W'(byte_i);
      for (int k = 0; k < pfp_pkg::N_COUNTS; k++) begin
        if (pos_q == POS_W'(pfp_pkg::COUNT_BASE_POS + 2 * k)) begin
          cnt_d[k] = {byte_i[pfp_pkg::HIGH_W-1:0], pfp_pkg::BYTE_W'(0)};
        end else if (pos_q == POS_W'(pfp_pkg::COUNT_BASE_POS + 2 * k + 1)) begin
          cnt_d[k] = {cnt_q[k][pfp_pkg::COUNT_W-1:pfp_pkg::BYTE_W], byte_i};
        end
      end
      pos_d = pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q  <= 1'b0;
      half_seen_q <= 1'b0;
      pos_q       <= '0;
    end else if (advance_i) begin
      in_frame_q  <= in_frame_d;
      half_seen_q <= half_seen_d;
      pos_q       <= pos_d;
    end
  end

  // Sum, checksum byte and counts are always rewritten inside a frame
  // before they are read, so they take no reset.
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      sum_q     <= sum_d;
      csum_hi_q <= csum_hi_d;
      cnt_q     <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/pfp_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfp_out_stage: result register of the frame parser
// Holds one finished result until the receiver takes it.
// ----------------------------------------------------------------------------
module pfp_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire pfp_pkg::result_t  result_i,
  input  wire logic              ready_i,
  output      logic              valid_o,
  output      logic              can_take_o,
  output      pfp_pkg::result_t  result_o
);

  logic             valid_q;
  pfp_pkg::result_t data_q;

  assign can_take_o = !valid_q || ready_i;
  assign valid_o    = valid_q;
  assign result_o   = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (can_take_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && can_take_o) begin
      data_q <= result_i;
    end
  end

endmodule

`default_nettype wire
